// ===== design/pbra_pkg.sv =====
// ----------------------------------------------------------------------------
// pbra_pkg: shared constants and types for the page bitmap range allocator
// Page geometry, request and status codes, and the word scan result.
// ----------------------------------------------------------------------------
package pbra_pkg;

  // window geometry
  localparam int MAP_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = $clog2(MAP_PAGES);
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int BM_WORDS   = MAP_PAGES / WORD_W;
  localparam int WA_W       = $clog2(BM_WORDS);

  // field widths
  localparam int ADDR_W = 48;
  localparam int LEN_W  = 32;
  localparam int CNT_W  = LEN_W - PAGE_SHIFT + 1;
  localparam int RUN_W  = PG_W + 1;

  // request kinds
  localparam logic [1:0] REQ_ANON    = 2'd0;
  localparam logic [1:0] REQ_FIXED   = 2'd1;
  localparam logic [1:0] REQ_UNMAP   = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  // result status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // first fit outcome for one bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
    logic [RUN_W-1:0] run_out;
  } fit_res_t;

  // bitmap write port
  typedef struct packed {
    logic              en;
    logic [WA_W-1:0]   addr;
    logic [WORD_W-1:0] word;
  } bm_wr_t;

endpackage

// ===== design/pbra_bitmap_mem.sv =====
// ----------------------------------------------------------------------------
// pbra_bitmap_mem: page occupancy bitmap storage
// One read and one write port, registered read. Per-word valid flags make
// every word read as all free after reset until it is first written.
// ----------------------------------------------------------------------------
module pbra_bitmap_mem
  import pbra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [WA_W-1:0]   rd_addr,
  output logic [WORD_W-1:0] rd_word,
  input  bm_wr_t            wr
);

  logic [WORD_W-1:0]   mem [BM_WORDS];
  logic [BM_WORDS-1:0] valid;
  logic [WORD_W-1:0]   rd_q;
  logic                rd_vq;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.word;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // valid flags cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_vq <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vq <= valid[rd_addr];
      end
    end
  end

  assign rd_word = rd_vq ? rd_q : '0;

endmodule

// ===== design/pbra_run_finder.sv =====
// ----------------------------------------------------------------------------
// pbra_run_finder: first fit search over one bitmap word
// Continues a free run from earlier words and finds the first page at which
// a run of the needed length ends, or the run carried into the next word.
// ----------------------------------------------------------------------------
module pbra_run_finder
  import pbra_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [RUN_W-1:0]  run_in,
  input  logic [CNT_W-1:0]  cnt,
  output fit_res_t          res
);

  logic [WORD_W-1:0] r [BIT_W+1];
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] m;
  logic              first;
  logic [BIT_W:0]    tz;
  logic [BIT_W:0]    lz;
  logic [BIT_W-1:0]  pos_m;
  logic              short_run;
  logic              pref_hit;

  // free runs of power of two lengths ending at each bit
  always_comb begin
    r[0] = ~word;
    for (int b = 1; b <= BIT_W; b++) begin
      r[b] = r[b-1] & (r[b-1] << (1 << (b-1)));
    end
  end

  // windows of exactly cnt free pages inside the word
  always_comb begin
    acc   = '1;
    first = 1'b1;
    for (int b = 0; b <= BIT_W; b++) begin
      if (cnt[b]) begin
        acc   = first ? (r[b] & acc) : (r[b] & (acc << (1 << b)));
        first = 1'b0;
      end
    end
    short_run = (cnt <= CNT_W'(WORD_W));
    m         = short_run ? acc : '0;
  end

  // free prefix, free suffix and first window end
  always_comb begin
    tz    = (BIT_W+1)'(WORD_W);
    lz    = (BIT_W+1)'(WORD_W);
    pos_m = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        tz = (BIT_W+1)'(i);
      end
      if (m[i]) begin
        pos_m = BIT_W'(i);
      end
    end
    for (int i = 0; i < WORD_W; i++) begin
      if (word[i]) begin
        lz = (BIT_W+1)'(WORD_W - 1 - i);
      end
    end
  end

  // a run continued from below ends before any run wholly inside the word
  always_comb begin
    pref_hit    = (CNT_W'(run_in) + CNT_W'(tz)) >= cnt;
    res.found   = pref_hit || (m != '0);
    res.pos     = pref_hit ? BIT_W'(cnt - CNT_W'(run_in) - CNT_W'(1)) : pos_m;
    res.run_out = (word == '0) ? (run_in + RUN_W'(WORD_W)) : RUN_W'(lz);
  end

endmodule

// ===== design/page_bitmap_range_allocator.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_range_allocator: page bitmap range allocator
// Map, fixed map, unmap and reserve over a page occupancy bitmap kept in a
// 64 x 64 bit memory, with first fit search for anonymous maps.
// ----------------------------------------------------------------------------
//  channel    direction  fields
//  s_axis     in         tuser: req_type; tdata: address, length_bytes
//  m_axis     out        tdata: result_address, status
//  cfg        in         cfg_wdata: base_address
//
// One request reads the bitmap word by word through the single read port: a
// hint check of up to 64 words, falling back to first fit when the hint is
// busy, a first fit scan of up to 64 words and a read-modify-write pass over
// the words of the range. Reset clears the bitmap at once through per-word
// valid flags.
// A new request is taken while a finished result waits in the output
// register; a stalled result holds the block only at the end of the next one.
// ----------------------------------------------------------------------------
module page_bitmap_range_allocator
  import pbra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [79:0]       s_axis_tdata,  // address[47:0], length_bytes[79:48]
  input  logic [1:0]        s_axis_tuser,  // req_type[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,  // result_address[47:0], status[49:48]
  input  logic              cfg_wen,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [1:0] M_HCHK = 2'd0;
  localparam logic [1:0] M_FIT  = 2'd1;
  localparam logic [1:0] M_MARK = 2'd2;

  logic [1:0]        state, state_next;
  logic [1:0]        mode, mode_next;
  logic [ADDR_W-1:0] base_address;
  logic [1:0]        typ, typ_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [PG_W-1:0]   idx, idx_next;
  logic              inwin, inwin_next;
  logic [PG_W-1:0]   sp, sp_next;
  logic [PG_W-1:0]   ep, ep_next;
  logic              setv, setv_next;
  logic              fit, fit_next;
  logic [1:0]        status, status_next;
  logic [WA_W:0]     ptr, ptr_next;
  logic [WA_W-1:0]   lw, lw_next;
  logic [RUN_W-1:0]  run, run_next;
  logic              rd_v;
  logic [WA_W-1:0]   rd_w;
  logic              out_v, out_v_next;
  logic [ADDR_W-1:0] out_addr, out_addr_next;
  logic [1:0]        out_st, out_st_next;

  logic              s_fire;
  logic              issue;
  logic [WORD_W-1:0] rd_word;
  bm_wr_t            wr;
  fit_res_t          fr;
  logic [BIT_W-1:0]  lo, hi;
  logic [WORD_W-1:0] mask;
  logic [PAGE_SHIFT+CNT_W-1:0] len_up;
  logic [ADDR_W:0]   diff;
  logic [CNT_W:0]    end_raw;
  logic [PG_W-1:0]   end_cl;
  logic              hint_ok;
  logic [CNT_W:0]    start_full;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {6'd0, out_st, out_addr};

  // bitmap store and word search
  pbra_bitmap_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (ptr[WA_W-1:0]),
    .rd_word (rd_word),
    .wr      (wr)
  );

  pbra_run_finder u_fit (
    .word   (rd_word),
    .run_in (run),
    .cnt    (cnt),
    .res    (fr)
  );

  // request decode arithmetic
  always_comb begin
    len_up  = (PAGE_SHIFT+CNT_W)'(s_axis_tdata[79:48]) + (PAGE_SHIFT+CNT_W)'(PAGE_BYTES - 1);
    diff    = {1'b0, s_axis_tdata[47:0]} - {1'b0, base_address};
    end_raw = (CNT_W+1)'(idx) + (CNT_W+1)'(cnt) - (CNT_W+1)'(1);
    end_cl  = (end_raw > (CNT_W+1)'(MAP_PAGES - 1)) ? PG_W'(MAP_PAGES - 1)
                                                    : end_raw[PG_W-1:0];
    hint_ok = (addr != '0) && inwin &&
              ((CNT_W+1)'(idx) + (CNT_W+1)'(cnt) <= (CNT_W+1)'(MAP_PAGES));
  end

  // bits of the current word that fall inside the range
  always_comb begin
    lo   = (rd_w == sp[PG_W-1:BIT_W]) ? sp[BIT_W-1:0] : '0;
    hi   = (rd_w == ep[PG_W-1:BIT_W]) ? ep[BIT_W-1:0] : '1;
    mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi));
    start_full = (CNT_W+1)'({rd_w, fr.pos}) + (CNT_W+1)'(1) - (CNT_W+1)'(cnt);
  end

  // sequencer
  always_comb begin
    state_next    = state;
    mode_next     = mode;
    typ_next      = typ;
    addr_next     = addr;
    cnt_next      = cnt;
    idx_next      = idx;
    inwin_next    = inwin;
    sp_next       = sp;
    ep_next       = ep;
    setv_next     = setv;
    fit_next      = fit;
    status_next   = status;
    ptr_next      = ptr;
    lw_next       = lw;
    run_next      = run;
    out_v_next    = out_v && !m_axis_tready;
    out_addr_next = out_addr;
    out_st_next   = out_st;
    issue         = 1'b0;
    wr.en         = 1'b0;
    wr.addr       = rd_w;
    wr.word       = setv ? (rd_word | mask) : (rd_word & ~mask);

    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          typ_next   = s_axis_tuser;
          addr_next  = s_axis_tdata[47:0];
          cnt_next   = len_up[PAGE_SHIFT+CNT_W-1:PAGE_SHIFT];
          inwin_next = !diff[ADDR_W] && (diff[ADDR_W-1:PAGE_SHIFT+PG_W] == '0);
          idx_next   = diff[PAGE_SHIFT+PG_W-1:PAGE_SHIFT];
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        fit_next    = 1'b0;
        status_next = ST_OK;
        setv_next   = (typ != REQ_UNMAP);
        sp_next     = idx;
        ep_next     = end_cl;
        run_next    = '0;
        lw_next     = end_cl[PG_W-1:BIT_W];
        ptr_next    = {1'b0, idx[PG_W-1:BIT_W]};
        priority if (cnt == '0) begin
          state_next = S_DONE;
        end else if (typ == REQ_ANON) begin
          state_next = S_SCAN;
          if (hint_ok) begin
            mode_next = M_HCHK;
          end else begin
            mode_next = M_FIT;
            ptr_next  = '0;
            lw_next   = WA_W'(BM_WORDS - 1);
          end
        end else if (!inwin) begin
          status_next = ST_RANGE;
          state_next  = S_DONE;
        end else begin
          mode_next  = M_MARK;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        issue    = (ptr <= {1'b0, lw});
        ptr_next = issue ? ptr + (WA_W+1)'(1) : ptr;
        if (rd_v) begin
          unique case (mode)
            M_HCHK: begin
              if ((rd_word & mask) != '0) begin
                // hinted range busy, fall back to first fit
                issue     = 1'b0;
                mode_next = M_FIT;
                ptr_next  = '0;
                lw_next   = WA_W'(BM_WORDS - 1);
                run_next  = '0;
              end else if (rd_w == lw) begin
                issue     = 1'b0;
                mode_next = M_MARK;
                ptr_next  = {1'b0, sp[PG_W-1:BIT_W]};
              end
            end
            M_FIT: begin
              if (fr.found) begin
                issue     = 1'b0;
                fit_next  = 1'b1;
                sp_next   = start_full[PG_W-1:0];
                ep_next   = {rd_w, fr.pos};
                mode_next = M_MARK;
                ptr_next  = {1'b0, start_full[PG_W-1:BIT_W]};
                lw_next   = rd_w;
              end else begin
                run_next = fr.run_out;
                if (rd_w == WA_W'(BM_WORDS - 1)) begin
                  issue       = 1'b0;
                  status_next = ST_NOSPACE;
                  state_next  = S_DONE;
                end
              end
            end
            M_MARK: begin
              wr.en = 1'b1;
              if (rd_w == lw) begin
                issue      = 1'b0;
                state_next = S_DONE;
              end
            end
            default: begin
              issue      = 1'b0;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_v || m_axis_tready) begin
          out_v_next  = 1'b1;
          out_st_next = status;
          priority if (fit) begin
            out_addr_next = base_address + ADDR_W'({sp, {PAGE_SHIFT{1'b0}}});
          end else if (status == ST_NOSPACE) begin
            out_addr_next = '0;
          end else begin
            out_addr_next = addr;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= M_HCHK;
      base_address <= '0;
      rd_v         <= 1'b0;
      out_v        <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      rd_v  <= issue;
      out_v <= out_v_next;
      if (cfg_wen) begin
        base_address <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    typ      <= typ_next;
    addr     <= addr_next;
    cnt      <= cnt_next;
    idx      <= idx_next;
    inwin    <= inwin_next;
    sp       <= sp_next;
    ep       <= ep_next;
    setv     <= setv_next;
    fit      <= fit_next;
    status   <= status_next;
    ptr      <= ptr_next;
    lw       <= lw_next;
    run      <= run_next;
    rd_w     <= ptr[WA_W-1:0];
    out_addr <= out_addr_next;
    out_st   <= out_st_next;
  end

  // checks
  a_wr_in_mark: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (state == S_SCAN && mode == M_MARK && rd_v))
    else $error("bitmap write outside the marking pass");

  a_nospace_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[49:48] == ST_NOSPACE) |-> (m_axis_tdata[47:0] == '0))
    else $error("no space result with nonzero address");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_axis_tready)
    else $error("second beat taken while a request is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[49:48] != 2'd3))
    else $error("undefined status code");

endmodule

// ===== tb/sv/page_bitmap_range_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// page_bitmap_range_allocator_checker: scoreboard for the page allocator
// Watches the request, result and register channels. Keeps its own page
// bitmap and window base, works out the result of every accepted request
// and compares each result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module page_bitmap_range_allocator_checker
  import pbra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // address[47:0], length_bytes[79:48]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,   // result_address[47:0], status[49:48]
  input  logic        cfg_wen,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output int          fail_count,
  output int          request_count,
  output int          result_count,
  output int          pending
);

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } alloc_result_t;

  logic [WORD_W-1:0] shadow_bitmap [BM_WORDS];
  logic [ADDR_W-1:0] window_base;
  alloc_result_t     expected_results [$];

  function automatic bit page_taken(bit [63:0] p);
    if (p >= MAP_PAGES) return 1'b1;
    return shadow_bitmap[p[PG_W-1:BIT_W]][p[BIT_W-1:0]];
  endfunction

  task automatic set_pages(bit [63:0] first, bit [63:0] count, bit used);
    bit [63:0] p;
    for (p = first; p < first + count && p < MAP_PAGES; p++)
      shadow_bitmap[p[PG_W-1:BIT_W]][p[BIT_W-1:0]] = used;
  endtask

  // predicted outcome of one request, updating the bitmap
  task automatic predict_allocation(input logic [1:0] kind, input logic [ADDR_W-1:0] a,
                                    input logic [LEN_W-1:0] len);
    bit [63:0]     cnt, idx, run, p, room, first;
    bit            in_win, hint_ok, found;
    alloc_result_t r;
    cnt = ({32'b0, len} + PAGE_BYTES - 1) / PAGE_BYTES;
    r.addr = a;
    r.status = ST_OK;
    in_win = 1'b0;
    idx = 0;
    if (a >= window_base) begin
      idx = ({16'b0, a} - {16'b0, window_base}) / PAGE_BYTES;
      in_win = idx < MAP_PAGES;
    end
    if (cnt != 0) begin
      if (kind == REQ_ANON) begin
        hint_ok = a != 0 && in_win && cnt <= MAP_PAGES - idx;
        for (p = idx; hint_ok && p < idx + cnt; p++)
          if (page_taken(p)) hint_ok = 1'b0;
        if (hint_ok) begin
          set_pages(idx, cnt, 1'b1);
        end else begin
          // lowest free run of the needed size
          run = 0;
          found = 1'b0;
          for (p = 0; p < MAP_PAGES && !found; p++) begin
            if (page_taken(p)) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                first = p + 1 - cnt;
                set_pages(first, cnt, 1'b1);
                r.addr = window_base + first[ADDR_W-1:0] * PAGE_BYTES;
                found = 1'b1;
              end
            end
          end
          if (!found) begin
            r.addr = '0;
            r.status = ST_NOSPACE;
          end
        end
      end else if (!in_win) begin
        r.status = ST_RANGE;
      end else begin
        room = MAP_PAGES - idx;
        set_pages(idx, (cnt < room) ? cnt : room, kind != REQ_UNMAP);
      end
    end
    expected_results.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] want,
                                 logic [ADDR_W-1:0] got);
    $display("mismatch in result %0d: %s expected 0x%0h got 0x%0h",
             result_count, what, want, got);
    fail_count++;
  endtask

  // monitor: results are compared before the same edge's request is queued
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      foreach (shadow_bitmap[w]) shadow_bitmap[w] = '0;
      window_base = '0;
      expected_results.delete();
      fail_count = 0;
      request_count = 0;
      result_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat, address", '0, m_axis_tdata[47:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[47:0] !== want.addr)
            report_mismatch("result_address", want.addr, m_axis_tdata[47:0]);
          if (m_axis_tdata[49:48] !== want.status)
            report_mismatch("status", {46'b0, want.status}, {46'b0, m_axis_tdata[49:48]});
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_allocation(s_axis_tuser, s_axis_tdata[47:0], s_axis_tdata[79:48]);
        request_count++;
      end
      if (cfg_wen) window_base = cfg_wdata;
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/sv/tb_page_bitmap_range_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_page_bitmap_range_allocator: testbench for the page bitmap allocator
// Drives directed and random map, fixed map, unmap and reserve requests over
// several window bases and idling mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_page_bitmap_range_allocator;
  import pbra_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata;   // address[47:0], length_bytes[79:48]
  logic [1:0]        s_axis_tuser;   // req_type[1:0]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [55:0]       m_axis_tdata;   // result_address[47:0], status[49:48]
  logic              cfg_wen;
  logic [ADDR_W-1:0] cfg_wdata;

  int fail_count, request_count, result_count, pending;
  int tx_idle_pct, rx_stall_pct, cycles;
  bit hold_off_req;
  bit hold_off_done;
  logic [ADDR_W-1:0] cur_base;

  page_bitmap_range_allocator dut (.*);
  page_bitmap_range_allocator_checker chk (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    hold_off_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // one request beat, then an optional gap
  task automatic send_request(logic [1:0] kind, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {len, a};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // let every outstanding result come back with the sender quiet
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    cur_base = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 20) return ADDR_W'({$urandom, $urandom});
    if (sel < 30) return cur_base + {$urandom_range(0, 4095), 12'h0} + $urandom_range(0, 4095);
    return cur_base + {$urandom_range(0, 4095), 12'h0};
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 15) return $urandom;
    if (sel < 30) return $urandom_range(1, 512 * PAGE_BYTES);
    return $urandom_range(1, 16) * PAGE_BYTES - $urandom_range(0, 3) * 1000;
  endfunction

  task automatic random_requests(int count);
    int sel;
    logic [1:0] kind;
    repeat (count) begin
      sel = $urandom_range(99);
      kind = (sel < 40) ? REQ_ANON : (sel < 55) ? REQ_FIXED : (sel < 85) ? REQ_UNMAP
                                                            : REQ_RESERVE;
      send_request(kind, pick_address(), pick_length());
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= REQ_ANON;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    hold_off_req = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    cur_base = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges of the window and every request kind
    write_base(48'h0000_1000_0000);
    send_request(REQ_ANON, 48'h0, 32'h0);
    send_request(REQ_FIXED, 48'h5, 32'h0);
    send_request(REQ_UNMAP, cur_base, 32'h0);
    send_request(REQ_RESERVE, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_request(REQ_ANON, 48'h0, 32'h1);
    send_request(REQ_ANON, cur_base + 48'h64000, 32'h2001);
    send_request(REQ_ANON, cur_base + 48'h65000, 32'h1000);
    send_request(REQ_ANON, cur_base + 48'hFFF000, 32'h2000);
    send_request(REQ_ANON, 48'h5, 32'h1000);
    send_request(REQ_FIXED, cur_base + 48'hFFE123, 32'h10000);
    send_request(REQ_FIXED, 48'hFFF_FFFF, 32'h1000);
    send_request(REQ_UNMAP, cur_base + 48'h100_0000, 32'h1000);
    send_request(REQ_RESERVE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_ANON, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_UNMAP, cur_base + 48'h64FFF, 32'h1);
    send_request(REQ_RESERVE, cur_base, 32'h100_0000);
    send_request(REQ_ANON, 48'h0, 32'h1000);
    send_request(REQ_UNMAP, cur_base + 48'h3000, 32'h3000);
    send_request(REQ_ANON, 48'h0, 32'h4000);
    send_request(REQ_ANON, 48'h0, 32'h3000);
    send_request(REQ_UNMAP, cur_base, 32'hFFFF_FFFF);
    drain_results();

    // pressure: results held back while requests keep coming
    hold_off_req = 1'b1;
    random_requests(40);
    drain_results();

    // phase: window at address zero, no idling
    write_base('0);
    random_requests(110);
    drain_results();

    // phase: window at the top of the address space, sender idling
    write_base(48'hFFFF_FFFF_F000);
    tx_idle_pct = 54;
    random_requests(110);
    drain_results();

    // phase: random base, receiver stalling
    write_base(ADDR_W'({$urandom, $urandom}));
    tx_idle_pct = 0;
    rx_stall_pct = 54;
    random_requests(110);
    drain_results();

    // phase: aligned base, both sides idling
    write_base({16'($urandom_range(0, 32'hFFFF)), 4'($urandom_range(0, 15)), 28'h0});
    tx_idle_pct = 11;
    rx_stall_pct = 11;
    random_requests(110);
    drain_results();
    repeat (150) @(posedge clk);

    $display("covered %0d requests and %0d results over five window bases",
             request_count, result_count);
    $display("directed edge cases, a long result hold-off and four idling mixes");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
